// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the valve timer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while in reset, fixed message
`define WSTV_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("wstv assertion failed");

// clocked check, disabled while in reset, caller message
`define WSTV_ASSERT_MSG(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`endif

// ----- sv/wstv_pkg.sv -----
// ----------------------------------------------------------------------------
// wstv_pkg
// Types, constants and helpers for the weekly slot timer valve.
// ----------------------------------------------------------------------------
`default_nettype none

package wstv_pkg;

    localparam int SLOT_COUNT = 6;
    localparam int SLOT_IDX_W = 3;
    localparam int WORD_W     = 31;
    localparam int FLOW_W     = 16;
    localparam int REQ_W      = 16;
    localparam int RUN_W      = 12;
    localparam int AGE_W      = 5;
    localparam int CFG_ADDR_W = 3;

    localparam logic [RUN_W-1:0]      MAX_RUN          = 12'd3600;
    localparam logic [5:0]            START_WINDOW     = 6'd5;
    localparam logic [AGE_W-1:0]      WARN_SPACING     = 5'd30;
    localparam logic [AGE_W-1:0]      WARN_AGE_MAX     = 5'd31;
    localparam logic [2:0]            WEEKDAY_NONE     = 3'd7;
    localparam logic [WORD_W-1:0]     SLOT_RESET       = 31'd314574590;
    localparam logic [FLOW_W-1:0]     FLOW_LEVEL_RESET = 16'd20;
    localparam logic [CFG_ADDR_W-1:0] CFG_FLOW_LEVEL   = 3'd6;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_MODE  = 2'd3
    } op_t;

    typedef logic [WORD_W-1:0] slot_word_t;

    typedef struct packed {
        op_t         operation;
        logic [15:0] run_seconds;
        logic        new_mode;
        logic        clock_valid;
        logic [2:0]  weekday;
        logic [4:0]  hour_now;
        logic [5:0]  minute_now;
        logic [5:0]  second_now;
        logic [15:0] flow_rate;
    } in_word_t;

    typedef struct packed {
        logic        valve_open;
        logic        run_active;
        logic        mode_now;
        logic [11:0] seconds_left;
        logic [2:0]  fired_slot;
        logic        run_finished;
        logic        flow_anomaly;
    } out_word_t;

    typedef struct packed {
        logic                  hit;
        logic [SLOT_IDX_W-1:0] fired;
        logic [RUN_W-1:0]      duration;
    } match_t;

    function automatic logic [RUN_W-1:0] clamp_run(input logic [REQ_W-1:0] s);
        logic [RUN_W-1:0] r;
        if (s > REQ_W'(MAX_RUN))
        begin
            r = MAX_RUN;
        end
        else
        begin
            r = s[RUN_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/wstv_match.sv -----
// ----------------------------------------------------------------------------
// wstv_match
// Compare all start slots with the wall clock and pick the lowest hit.
// ----------------------------------------------------------------------------
`default_nettype none

module wstv_match
    import wstv_pkg::*;
(
    input  slot_word_t [SLOT_COUNT-1:0] slots,
    input  logic [2:0]                  weekday,
    input  logic [4:0]                  hour_now,
    input  logic [5:0]                  minute_now,
    output match_t                      match
);

    logic [SLOT_COUNT-1:0] hit_vec;

    always_comb
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            hit_vec[i] = slots[i][0]
                      && (weekday != WEEKDAY_NONE)
                      && slots[i][5'(weekday) + 5'd1]
                      && (slots[i][12:8] == hour_now)
                      && (slots[i][18:13] == minute_now);
        end
    end

    always_comb
    begin
        match = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                match.hit      = 1'b1;
                match.fired    = SLOT_IDX_W'(i + 1);
                match.duration = clamp_run(REQ_W'(slots[i][30:19]));
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/weekly_slot_timer_valve.sv -----
// ----------------------------------------------------------------------------
// weekly_slot_timer_valve
// One-valve weekly timer: six start slots, timed runs, idle flow warning.
// ----------------------------------------------------------------------------
//  channel | signals                      | word
//  input   | in_valid / in_ready          | in_data  (in_word_t)
//  output  | out_valid / out_ready        | out_data (out_word_t)
//  config  | cfg_we, cfg_addr             | cfg_data (31 bits)
//
//  One word per cycle sustained while out_ready stays high; a word passes from
//  the input register to the result register, where out_valid is raised.
//  The slot compare and run counter update sit between the input register
//  and the result register and are combinational.
//  rst_n clears state, flags and config to their defaults; no clearing pass.
//  A stalled result holds; one more word is taken into the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module weekly_slot_timer_valve
    import wstv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_word_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_word_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [WORD_W-1:0]     cfg_data
);

    `include "assert_macros.svh"

    slot_word_t [SLOT_COUNT-1:0] slot_reg;
    logic [FLOW_W-1:0]           level_reg;

    in_word_t  in_reg;
    logic      in_valid_reg;
    out_word_t out_reg, out_next;
    logic      out_valid_reg;

    logic             running_reg, running_next;
    logic             mode_reg, mode_next;
    logic [RUN_W-1:0] length_reg, length_next;
    logic [RUN_W-1:0] elapsed_reg, elapsed_next;
    logic [AGE_W-1:0] age_reg, age_next;

    logic             advance;
    match_t           match;
    logic [AGE_W-1:0] age_inc;
    logic [RUN_W-1:0] elapsed_inc;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    wstv_match u_match
    (
        .slots      (slot_reg),
        .weekday    (in_reg.weekday),
        .hour_now   (in_reg.hour_now),
        .minute_now (in_reg.minute_now),
        .match      (match)
    );

    assign age_inc     = (age_reg < WARN_AGE_MAX) ? age_reg + 1'b1 : age_reg;
    assign elapsed_inc = (elapsed_reg == {RUN_W{1'b1}}) ? elapsed_reg : elapsed_reg + 1'b1;

    always_comb
    begin
        running_next = running_reg;
        mode_next    = mode_reg;
        length_next  = length_reg;
        elapsed_next = elapsed_reg;
        age_next     = age_reg;
        out_next     = '0;
        case (in_reg.operation)
            OP_TICK:
            begin
                age_next = age_inc;
                if (!running_reg && (in_reg.flow_rate > level_reg) && (age_inc >= WARN_SPACING))
                begin
                    out_next.flow_anomaly = 1'b1;
                    age_next              = '0;
                end
                if (running_reg)
                begin
                    if (elapsed_inc >= length_reg)
                    begin
                        running_next          = 1'b0;
                        mode_next             = 1'b0;
                        length_next           = '0;
                        elapsed_next          = '0;
                        out_next.run_finished = 1'b1;
                    end
                    else
                    begin
                        elapsed_next = elapsed_inc;
                    end
                end
                else if (!mode_reg && in_reg.clock_valid
                         && (in_reg.second_now < START_WINDOW) && match.hit)
                begin
                    running_next        = 1'b1;
                    length_next         = match.duration;
                    elapsed_next        = '0;
                    out_next.fired_slot = match.fired;
                end
            end
            OP_START:
            begin
                running_next = 1'b1;
                length_next  = clamp_run(in_reg.run_seconds);
                elapsed_next = '0;
            end
            OP_STOP:
            begin
                running_next = 1'b0;
                mode_next    = 1'b0;
                length_next  = '0;
                elapsed_next = '0;
            end
            OP_MODE:
            begin
                mode_next = in_reg.new_mode;
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
        out_next.valve_open = running_next;
        out_next.run_active = running_next;
        out_next.mode_now   = mode_next;
        if (running_next && (length_next > elapsed_next))
        begin
            out_next.seconds_left = length_next - elapsed_next;
        end
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_reg[i] <= SLOT_RESET;
            end
            level_reg <= FLOW_LEVEL_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_addr < CFG_ADDR_W'(SLOT_COUNT))
            begin
                slot_reg[cfg_addr] <= cfg_data;
            end
            else if (cfg_addr == CFG_FLOW_LEVEL)
            begin
                level_reg <= cfg_data[FLOW_W-1:0];
            end
        end
    end

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            running_reg   <= 1'b0;
            mode_reg      <= 1'b0;
            length_reg    <= '0;
            elapsed_reg   <= '0;
            age_reg       <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                running_reg   <= running_next;
                mode_reg      <= mode_next;
                length_reg    <= length_next;
                elapsed_reg   <= elapsed_next;
                age_reg       <= age_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_reg <= in_data;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    `WSTV_ASSERT(a_idle_clear, clk, rst_n,
        !running_reg |-> (length_reg == '0 && elapsed_reg == '0))
    `WSTV_ASSERT_MSG(a_fire_runs, clk, rst_n,
        (out_valid_reg && out_reg.fired_slot != '0)
            |-> (out_reg.run_active && !out_reg.run_finished),
        "slot fired without an active run")
    `WSTV_ASSERT_MSG(a_finish_auto, clk, rst_n,
        (advance && out_next.run_finished) |=> (!running_reg && !mode_reg && out_valid_reg),
        "timed-out run left state active")

endmodule

`default_nettype wire
